/* src/rbd_pkg.sv */
`timescale 1ns / 1ps

package rbd_pkg;

   // Ring store geometry.
   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   // Field widths of the request and response.
   localparam int WORD_W  = 32;
   localparam int KIND_W  = 2;
   localparam int OCC_W   = 11;
   localparam int RSP_W   = 48;

   // Depth of the command queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Value returned by a pop from an empty deque.
   localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

   // Operation codes carried on req_tuser.
   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_FRONT = 2'd0,
      KIND_POP_FRONT  = 2'd1,
      KIND_PUSH_BACK  = 2'd2,
      KIND_POP_BACK   = 2'd3
   } kind_type;

   // One classified request as handed from the front part to the back part.
   typedef struct packed {
      logic               write;
      logic               read;
      logic [ADDR_W-1:0]  addr;
      logic [WORD_W-1:0]  data;
      logic               was_empty;
      logic               overflow;
      logic [OCC_W-1:0]   occupancy;
   } cmd_type;

   localparam int CMD_W = $bits(cmd_type);

endpackage

/* src/rbd_ram.sv */
`timescale 1ns / 1ps

module rbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/rbd_front.sv */
`timescale 1ns / 1ps

module rbd_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        cmd_ready,
   input  logic [rbd_pkg::KIND_W-1:0]  req_kind,
   input  logic [rbd_pkg::WORD_W-1:0]  req_word,
   output logic                        cmd_valid,
   output rbd_pkg::cmd_type            cmd
);

   logic [rbd_pkg::ADDR_W-1:0]  front_ff, front_in;
   logic [rbd_pkg::ADDR_W-1:0]  back_ff, back_in;
   logic [rbd_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [rbd_pkg::ADDR_W-1:0]  front_up, front_down, back_up, back_down;
   logic                        is_full, is_empty, accept;
   rbd_pkg::kind_type           kind;

   assign kind      = rbd_pkg::kind_type'(req_kind);
   assign accept    = req_valid && cmd_ready;
   assign cmd_valid = req_valid;
   assign is_full   = (count_ff == rbd_pkg::COUNT_W'(rbd_pkg::CAPACITY));
   assign is_empty  = (count_ff == '0);

   // Modular pointer steps; the ends are compared so any capacity wraps cleanly.
   assign front_up   = (front_ff == rbd_pkg::ADDR_W'(rbd_pkg::CAPACITY - 1)) ? '0
                                                                         : front_ff + 1'b1;
   assign front_down = (front_ff == '0) ? rbd_pkg::ADDR_W'(rbd_pkg::CAPACITY - 1)
                                        : front_ff - 1'b1;
   assign back_up    = (back_ff == rbd_pkg::ADDR_W'(rbd_pkg::CAPACITY - 1)) ? '0
                                                                        : back_ff + 1'b1;
   assign back_down  = (back_ff == '0) ? rbd_pkg::ADDR_W'(rbd_pkg::CAPACITY - 1)
                                       : back_ff - 1'b1;

   // Classify the request and work out the pointer and count updates.
   always_comb begin
      front_in       = front_ff;
      back_in        = back_ff;
      count_in       = count_ff;
      cmd.write      = 1'b0;
      cmd.read       = 1'b0;
      cmd.addr       = front_ff;
      cmd.data       = req_word;
      cmd.was_empty  = 1'b0;
      cmd.overflow   = 1'b0;
      unique case (kind)
         rbd_pkg::KIND_PUSH_FRONT: begin
            if (is_full) begin
               cmd.overflow = 1'b1;
            end else begin
               cmd.write = 1'b1;
               cmd.addr  = front_down;
               front_in  = front_down;
               count_in  = count_ff + 1'b1;
            end
         end
         rbd_pkg::KIND_POP_FRONT: begin
            if (is_empty) begin
               cmd.was_empty = 1'b1;
            end else begin
               cmd.read = 1'b1;
               cmd.addr = front_ff;
               front_in = front_up;
               count_in = count_ff - 1'b1;
            end
         end
         rbd_pkg::KIND_PUSH_BACK: begin
            if (is_full) begin
               cmd.overflow = 1'b1;
            end else begin
               cmd.write = 1'b1;
               cmd.addr  = back_ff;
               back_in   = back_up;
               count_in  = count_ff + 1'b1;
            end
         end
         rbd_pkg::KIND_POP_BACK: begin
            if (is_empty) begin
               cmd.was_empty = 1'b1;
            end else begin
               cmd.read = 1'b1;
               cmd.addr = back_down;
               back_in  = back_down;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
      cmd.occupancy = rbd_pkg::OCC_W'(count_in);
   end

   // Pointers and count advance only on an accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

endmodule

/* src/rbd_cmd_queue.sv */
`timescale 1ns / 1ps

module rbd_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  rbd_pkg::cmd_type  push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output rbd_pkg::cmd_type  pop_cmd
);

   rbd_pkg::cmd_type            entry_ff [rbd_pkg::QUEUE_DEPTH];
   logic [rbd_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [rbd_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [rbd_pkg::QCNT_W-1:0]  count_ff, count_in;
   logic                        do_push, do_pop;

   assign push_ready = (count_ff != rbd_pkg::QCNT_W'(rbd_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill-count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == rbd_pkg::QPTR_W'(rbd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == rbd_pkg::QPTR_W'(rbd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* src/rbd_back.sv */
`timescale 1ns / 1ps

module rbd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   output logic                        cmd_ready,
   input  rbd_pkg::cmd_type            cmd,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rbd_pkg::RSP_W-1:0]   rsp_data
);

   logic                          pend_valid_ff, pend_valid_in;
   logic                          pend_read_ff;
   logic                          pend_empty_ff;
   logic                          pend_over_ff;
   logic [rbd_pkg::OCC_W-1:0]     pend_occ_ff;
   logic                          out_valid_ff, out_valid_in;
   logic [rbd_pkg::RSP_W-1:0]     out_data_ff;
   logic [rbd_pkg::RSP_W-1:0]     out_data_in;
   logic [rbd_pkg::WORD_W-1:0]    rd_word;
   logic [rbd_pkg::WORD_W-1:0]    pop_word;
   logic                          pend_move, issue;

   // The pending stage holds each command until the registered read data is available.
   assign pend_move = pend_valid_ff && (!out_valid_ff || rsp_ready);
   assign cmd_ready = !pend_valid_ff || pend_move;
   assign issue     = cmd_valid && cmd_ready;

   rbd_ram #(
      .WIDTH (rbd_pkg::WORD_W),
      .DEPTH (rbd_pkg::CAPACITY)
   ) u_ring (
      .clock   (clock),
      .wr_en   (issue && cmd.write),
      .wr_addr (cmd.addr),
      .wr_data (cmd.data),
      .rd_en   (issue && cmd.read),
      .rd_addr (cmd.addr),
      .rd_data (rd_word)
   );

   // Build the response word: pop_value, was_empty, overflow, occupancy.
   always_comb begin
      if (pend_read_ff) begin
         pop_word = rd_word;
      end else if (pend_empty_ff) begin
         pop_word = rbd_pkg::EMPTY_WORD;
      end else begin
         pop_word = '0;
      end
      out_data_in = rbd_pkg::RSP_W'({pend_occ_ff, pend_over_ff, pend_empty_ff, pop_word});
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (issue) begin
         pend_valid_in = 1'b1;
      end else if (pend_move) begin
         pend_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (pend_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (issue) begin
         pend_read_ff  <= cmd.read;
         pend_empty_ff <= cmd.was_empty;
         pend_over_ff  <= cmd.overflow;
         pend_occ_ff   <= cmd.occupancy;
      end
      if (pend_move) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

/* src/ring_buffer_deque_unit.sv */
`timescale 1ns / 1ps

// Channel    Direction  Handshake               Payload
// request    in         req_tvalid/req_tready   tdata push_value, tuser kind
// response   out        rsp_tvalid/rsp_tready   tdata pop_value..occupancy
//
// Each request yields one response, passing through the command queue, the pending
// read stage and the output register before rsp_tvalid rises; the sustained rate is
// one request per cycle while rsp_tready stays high. Reset clears the pointers, the
// count and all valid flags; the ring memory is not cleared. A stalled response holds
// in the output register while the pending read stage and the command queue take
// three more requests, after which req_tready drops.

module ring_buffer_deque_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [31:0] push_value
   input  logic [1:0]   req_tuser,   // [1:0] kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata    // [31:0] pop_value, [32] was_empty,
                                     // [33] overflow, [44:34] occupancy, zero pad
);

   logic              fe_valid;
   logic              q_ready;
   rbd_pkg::cmd_type  fe_cmd;
   logic              be_valid;
   logic              be_ready;
   rbd_pkg::cmd_type  be_cmd;

   assign req_tready = q_ready;

   // Front part: accepts and classifies requests, owns pointers and count.
   rbd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .cmd_ready (q_ready),
      .req_kind  (req_tuser),
      .req_word  (req_tdata),
      .cmd_valid (fe_valid),
      .cmd       (fe_cmd)
   );

   // Short queue decoupling classification from memory access.
   rbd_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fe_valid),
      .push_ready (q_ready),
      .push_cmd   (fe_cmd),
      .pop_valid  (be_valid),
      .pop_ready  (be_ready),
      .pop_cmd    (be_cmd)
   );

   // Back part: ring memory access and response register.
   rbd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (be_valid),
      .cmd_ready (be_ready),
      .cmd       (be_cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata)
   );

endmodule
